// File: hw/rtl/sspq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
`default_nettype none

package sspq_pkg;

  localparam int unsigned PRIO_BITS = 8;
  localparam int unsigned TAG_BITS  = 16;
  localparam int unsigned OCC_BITS  = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic                 kind;
    logic [PRIO_BITS-1:0] priority_req;
    logic [TAG_BITS-1:0]  task_tag;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [PRIO_BITS-1:0] out_priority;
    logic [TAG_BITS-1:0]  out_tag;
    logic [OCC_BITS-1:0]  occupancy;
  } rsp_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/sspq_cell.sv
// One slot of the sorted chain: compare, hold, shift or take the new entry.
`default_nettype none

module sspq_cell
  import sspq_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  wire        occupied_i,
  input  wire        left_keep_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  output logic       keep_o,
  output entry_t     entry_o
);

  entry_t entry_q, entry_d;

  // An occupied slot whose priority is lower or equal stays in place, so
  // equal priorities keep their arrival order.
  assign keep_o = occupied_i && (entry_q.prio <= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          entry_d = ctrl_i.new_entry;
        end else begin
          entry_d = left_entry_i;
        end
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: hw/rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue built as a chain of cells.
// Latency: the result of a request is on rsp_o, with valid_o high, in the
// cycle after the request is taken, for that one cycle only.
// Throughput: one request per cycle; busy_o never rises, since every cell
// updates in a single compare-and-shift step.
// Reset clears the fill count and the result strobe; slot contents stay
// undefined until written and are never read beyond the fill count.
`default_nettype none

module stable_sorted_priority_queue
  import sspq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output rsp_t rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d;
  logic          valid_q;
  rsp_t          rsp_q, rsp_d;

  cell_ctrl_t        ctrl;
  logic [DEPTH-1:0]  keep;
  logic [DEPTH-1:0]  occupied;
  entry_t            slot [DEPTH];

  logic accept;
  logic full;
  logic empty;

  // No request ever stalls, so the queue is always ready.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(DEPTH));
  assign empty  = (count_q == '0);

  // The broadcast that all cells see. A full insert and an empty remove
  // leave the chain untouched.
  always_comb begin
    ctrl.ins            = accept && (req_i.kind == KIND_INSERT) && !full;
    ctrl.rem            = accept && (req_i.kind == KIND_REMOVE) && !empty;
    ctrl.new_entry.prio = req_i.priority_req;
    ctrl.new_entry.tag  = req_i.task_tag;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_keep;

    assign occupied[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      // The head has nothing in front of it, so a new entry that beats it
      // lands here directly.
      assign left_keep  = 1'b1;
      assign left_entry = '0;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_entry = slot[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = slot[i+1];
    end

    sspq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied[i]),
      .left_keep_i   (left_keep),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .keep_o        (keep[i]),
      .entry_o       (slot[i])
    );
  end

  // The result is formed from the state before the update: on a remove the
  // head slot still holds the entry that leaves.
  always_comb begin
    count_d           = count_q;
    rsp_d.status      = ST_OK;
    rsp_d.out_priority = '0;
    rsp_d.out_tag     = '0;
    if (req_i.kind == KIND_INSERT) begin
      if (full) begin
        rsp_d.status = ST_FULL;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else begin
      if (empty) begin
        rsp_d.status = ST_EMPTY;
      end else begin
        count_d            = count_q - CW'(1);
        rsp_d.out_priority = slot[0].prio;
        rsp_d.out_tag      = slot[0].tag;
      end
    end
    rsp_d.occupancy = OCC_BITS'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Result payload needs no reset; the strobe qualifies it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the stable sorted priority queue.
`timescale 1ns / 100ps

module tb;
  import sspq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_ITEMS = 650;
  // The final stretch of random requests is sent back to back.
  localparam int unsigned TAIL_ITEMS = 100;
  // Results are registered and come in the cycle after the request is taken; the settle wait covers that.
  localparam int unsigned SETTLE_CYC = 4;

  // One row of the directed table. When pinned is set, the expected result
  // is the one typed into the row; otherwise it comes from the mirror below.
  typedef struct {
    req_t req;
    bit   pinned;
    rsp_t rsp;
  } step_t;

  logic clk_i;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic valid_o;
  rsp_t rsp_o;

  // The typed expectation travels with the request it belongs to.
  logic pin_en  = 1'b0;
  rsp_t pin_rsp = '0;

  // Mirror of the queue contents, slot 0 the head, and its fill count.
  entry_t mirror_slot [DEPTH];
  int     mirror_count = 0;

  // Results still owed by the block, oldest first.
  rsp_t awaited_rsp [$];

  int unsigned fails     = 0;
  int unsigned n_taken   = 0;
  int unsigned n_inserts = 0;
  int unsigned n_removes = 0;
  int unsigned n_full    = 0;
  int unsigned n_empty   = 0;
  int unsigned peak_fill = 0;

  step_t plan [$];

  stable_sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one request to the mirror and returns the result it must cause.
  // An insert goes behind every held entry of lower or equal priority, so
  // equal priorities leave in arrival order.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    int   pos;
    o        = '0;
    o.status = ST_OK;
    if (r.kind == KIND_INSERT) begin
      if (mirror_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < mirror_count && mirror_slot[pos].prio <= r.priority_req) pos++;
        for (int i = mirror_count; i > pos; i--) mirror_slot[i] = mirror_slot[i-1];
        mirror_slot[pos] = '{prio: r.priority_req, tag: r.task_tag};
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      o.out_priority = mirror_slot[0].prio;
      o.out_tag      = mirror_slot[0].tag;
      for (int i = 1; i < mirror_count; i++) mirror_slot[i-1] = mirror_slot[i];
      mirror_count--;
    end
    o.occupancy = OCC_BITS'(mirror_count);
    return o;
  endfunction

  function automatic rsp_t make_rsp(input status_e s, input logic [PRIO_BITS-1:0] p,
                                    input logic [TAG_BITS-1:0] t,
                                    input logic [OCC_BITS-1:0] occ);
    rsp_t o;
    o.status       = s;
    o.out_priority = p;
    o.out_tag      = t;
    o.occupancy    = occ;
    return o;
  endfunction

  task automatic add_row(input logic kind, input logic [PRIO_BITS-1:0] p,
                         input logic [TAG_BITS-1:0] t, input bit pinned, input rsp_t r);
    step_t s;
    s.req.kind         = kind;
    s.req.priority_req = p;
    s.req.task_tag     = t;
    s.pinned           = pinned;
    s.rsp              = r;
    plan.push_back(s);
  endtask

  // Presents one request and returns at the edge that takes it.
  task automatic issue(input req_t r, input bit pinned, input rsp_t p);
    start_i <= 1'b1;
    req_i   <= r;
    pin_en  <= pinned;
    pin_rsp <= p;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Idles the request side; the payload carries noise that must be ignored.
  task automatic hold_off(input int unsigned n);
    start_i <= 1'b0;
    req_i   <= req_t'($urandom());
    pin_en  <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stops sending and waits until every owed result has been seen.
  task automatic drain();
    start_i <= 1'b0;
    pin_en  <= 1'b0;
    do @(posedge clk_i); while (awaited_rsp.size() != 0);
  endtask

  // Checker and predictor share one process: results seen at this edge
  // belong to requests taken at earlier edges, so the check runs first and
  // the request taken at this edge is predicted afterwards.
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t calc;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (awaited_rsp.size() == 0) begin
          $error("result with no request outstanding: %p", rsp_o);
          fails++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_o.status);
            fails++;
          end
          if (rsp_o.out_priority !== want.out_priority) begin
            $error("out_priority: expected %0d, got %0d", want.out_priority,
                   rsp_o.out_priority);
            fails++;
          end
          if (rsp_o.out_tag !== want.out_tag) begin
            $error("out_tag: expected 0x%04h, got 0x%04h", want.out_tag, rsp_o.out_tag);
            fails++;
          end
          if (rsp_o.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_o.occupancy);
            fails++;
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        calc = serve_request(req_i);
        awaited_rsp.push_back(pin_en ? pin_rsp : calc);
        n_taken++;
        case (calc.status)
          ST_FULL:  n_full++;
          ST_EMPTY: n_empty++;
          default: begin
            if (req_i.kind == KIND_INSERT) n_inserts++;
            else n_removes++;
          end
        endcase
        if (mirror_count > peak_fill) peak_fill = mirror_count;
      end
    end
  end

  initial begin
    req_t r;
    int   sel;
    int   fill_pct [10];
    logic [PRIO_BITS-1:0] fill_prio [16];

    // Insert share per random phase, swinging between filling and draining
    // so both the full and the empty queue are reached repeatedly.
    fill_pct  = '{90, 20, 95, 50, 10, 75, 60, 5, 85, 50};
    // Priorities for the directed fill, with many ties and both extremes.
    fill_prio = '{8'd7, 8'd2, 8'd7, 8'd255, 8'd0, 8'd2, 8'd7, 8'd7,
                  8'd0, 8'd255, 8'd2, 8'd7, 8'd128, 8'd0, 8'd7, 8'd2};

    // Directed part. Remove on empty, then single entries at both extremes.
    add_row(KIND_REMOVE, 8'd0, 16'h0000, 1'b1, make_rsp(ST_EMPTY, 8'd0, 16'h0000, 5'd0));
    add_row(KIND_INSERT, 8'd255, 16'hFFFF, 1'b1, make_rsp(ST_OK, 8'd0, 16'h0000, 5'd1));
    add_row(KIND_REMOVE, 8'd0, 16'h1234, 1'b1, make_rsp(ST_OK, 8'd255, 16'hFFFF, 5'd0));
    add_row(KIND_INSERT, 8'd0, 16'h0000, 1'b1, make_rsp(ST_OK, 8'd0, 16'h0000, 5'd1));
    add_row(KIND_REMOVE, 8'hFF, 16'hFFFF, 1'b1, make_rsp(ST_OK, 8'd0, 16'h0000, 5'd0));
    // Fill to the brim with tied priorities; the order is left to the mirror.
    for (int i = 0; i < 16; i++) begin
      add_row(KIND_INSERT, fill_prio[i], 16'hA000 + 16'(i), 1'b0, '0);
    end
    // An insert into the full queue is dropped.
    add_row(KIND_INSERT, 8'd1, 16'h5555, 1'b1, make_rsp(ST_FULL, 8'd0, 16'h0000, 5'd16));
    add_row(KIND_REMOVE, 8'd0, 16'h0000, 1'b0, '0);
    // A new priority-0 entry must queue up behind the older ones.
    add_row(KIND_INSERT, 8'd0, 16'h5A5A, 1'b0, '0);
    add_row(KIND_REMOVE, 8'd0, 16'h0000, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      issue(plan[i].req, plan[i].pinned, plan[i].rsp);
      if ($urandom_range(0, 3) == 0) hold_off($urandom_range(1, 16));
    end

    // Random part, in phases of varying insert share.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      sel            = $urandom_range(0, 9);
      r.kind         = ($urandom_range(0, 99) < fill_pct[(k / 65) % 10]) ? KIND_INSERT
                                                                          : KIND_REMOVE;
      r.priority_req = (sel == 0) ? 8'd0 :
                       (sel == 1) ? 8'd255 :
                       (sel < 6)  ? PRIO_BITS'($urandom_range(0, 3)) :
                                    PRIO_BITS'($urandom());
      r.task_tag     = TAG_BITS'($urandom());
      issue(r, 1'b0, '0);
      // Once in mid run the sender waits for every owed result.
      if (k == RAND_ITEMS / 2) drain();
      if (k < RAND_ITEMS - TAIL_ITEMS && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 16));
      end
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (awaited_rsp.size() != 0) begin
      $error("%0d results never arrived", awaited_rsp.size());
      fails++;
    end

    $display("Ran %0d requests: %0d inserts and %0d removes served, %0d inserts dropped",
             n_taken, n_inserts, n_removes, n_full);
    $display("on a full queue, %0d removes on an empty one; peak fill %0d of %0d.",
             n_empty, peak_fill, DEPTH);
    if (fails == 0) begin
      $display("stable_sorted_priority_queue test passed");
    end else begin
      $display("stable_sorted_priority_queue test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("stable_sorted_priority_queue test failed");
    $finish;
  end

endmodule
